// ===== hdl/efd_pkg.sv =====
// shared types, register codes and arithmetic helpers for the error diffusion dither
// no dependencies; imported by efd_diffuse, error_diffusion_dither and the testbench
package efd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int THR_W      = 8;
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } t_cfg_index;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 16'd480;
    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 8'd128;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    typedef logic signed [ERR_W-1:0] t_err;

    // everything the diffusion arithmetic hands back for one pixel
    typedef struct packed {
        logic white;
        t_err right_share;
        t_err down_left;
        t_err down_mid;
        t_err down_right;
    } t_diffuse;

    // clamp to the signed 11-bit range
    function automatic t_err sat11(input logic signed [12:0] v);
        t_err r;
        if (v > 13'sd1023) begin
            r = 11'sd1023;
        end else if (v < -13'sd1024) begin
            r = -11'sd1024;
        end else begin
            r = v[10:0];
        end
        return r;
    endfunction

    // divide by 16, truncating toward zero
    function automatic t_err div16(input logic signed [14:0] v);
        logic signed [14:0] b;
        b = v + (v[14] ? 15'sd15 : 15'sd0);
        b = b >>> 4;
        return b[10:0];
    endfunction

    // sign extend an error value for a 13-bit sum
    function automatic logic signed [12:0] ext13(input t_err v);
        return {{2{v[ERR_W-1]}}, v};
    endfunction

endpackage

// ===== hdl/error_diffusion_dither.sv =====
// error diffusion (floyd-steinberg) dither, 8-bit grey in, black or white out
// an accepted pixel passes through the stage 1 register, then the output register
// throughput: one pixel per clock; input stalls only while a held result blocks stage 1
// reset: synchronous active low; clears counters, carried errors and registers to defaults
// the line store has no reset; row 0 of every frame ignores it, so no clearing pass
// depends on efd_pkg and efd_diffuse
module error_diffusion_dither #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_wr_en,
    input  logic [efd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [efd_pkg::PIX_W-1:0]      i_pixel_in,
    // dithered output
    output logic                           o_result_valid,
    input  logic                           i_result_ready,
    output logic [efd_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_end_of_row,
    output logic                           o_end_of_frame
);
    import efd_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration registers
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [THR_W-1:0]    r_threshold;

    // position counters, advanced at input acceptance
    logic [CW-1:0]       r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;

    // stage 1: pixel waiting for its line store read
    logic                r_s1_valid, n_s1_valid;
    logic [PIX_W-1:0]    r_s1_pix;
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_last_col;
    logic                r_s1_last_row;
    logic                r_s1_row0;
    logic                r_fwd_valid, n_fwd_valid;
    t_err                r_fwd_data, n_fwd_data;
    t_err                r_rd_data;

    // carried errors along the row
    t_err                r_right, n_right;
    t_err                r_pend_left, n_pend_left;
    t_err                r_pend_mid, n_pend_mid;

    // last-column write held back to the next cycle, the ram has a single write port
    logic                r_def_valid, n_def_valid;
    logic [CW-1:0]       r_def_addr;
    t_err                r_def_data;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [PIX_W-1:0]    r_pixel_out;
    logic                r_eor;
    logic                r_eof;

    // line store: next row's error per column, read at acceptance,
    // written back when a pixel leaves stage 1 (the last column in the following cycle)
    t_err                line_mem [MAX_WIDTH];

    logic                accept;
    logic                s1_fire;
    logic [31:0]         width_ext;
    logic [CW-1:0]       col_last;
    logic [HEIGHT_W-1:0] row_last;
    logic                last_col;
    logic                last_row;
    logic [CW-1:0]       col_now;

    logic                s1_first_col;
    t_err                mem_val;
    t_err                incoming;
    t_err                right_in;
    t_diffuse            diff;

    logic                prim_we;
    logic                wr_en;
    logic [CW-1:0]       wr_addr;
    t_err                wr_data;

    // handshake: stage 1 drains into the output register whenever it is free or being taken
    assign s1_fire        = r_s1_valid && (!r_out_valid || i_result_ready);
    assign o_pixel_ready  = !r_s1_valid || s1_fire;
    assign accept         = i_pixel_valid && o_pixel_ready;

    // effective width clamped to 1..MAX_WIDTH, height of zero counts as one
    always_comb begin
        width_ext = 32'(r_width);
        if (width_ext == 32'd0) begin
            col_last = '0;
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(width_ext - 32'd1);
        end
        row_last = (r_height == '0) ? '0 : r_height - HEIGHT_W'(1);
        // a count at or past the last column (after a width change) ends the row
        last_col = (r_col >= col_last);
        last_row = (r_row >= row_last);
        col_now  = last_col ? col_last : r_col;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = col_now + CW'(1);
            end
        end
    end

    // stage 1 datapath
    always_comb begin
        s1_first_col = (r_s1_col == '0);
        // newest data wins: held-back write, then a captured write, then the ram read
        if (r_def_valid && r_def_addr == r_s1_col) begin
            mem_val = r_def_data;
        end else if (r_fwd_valid) begin
            mem_val = r_fwd_data;
        end else begin
            mem_val = r_rd_data;
        end
        incoming = r_s1_row0 ? '0 : mem_val;
        right_in = s1_first_col ? '0 : r_right;
    end

    efd_diffuse u_diffuse (
        .i_pixel     (r_s1_pix),
        .i_incoming  (incoming),
        .i_right     (right_in),
        .i_pend_left (r_pend_left),
        .i_pend_mid  (r_pend_mid),
        .i_first_col (s1_first_col),
        .i_threshold (r_threshold),
        .o_diffuse   (diff)
    );

    // ram write port: down-left share of a finished column, else the held-back last column
    always_comb begin
        prim_we = s1_fire && !s1_first_col;
        wr_en   = prim_we || r_def_valid;
        wr_addr = prim_we ? r_s1_col - CW'(1) : r_def_addr;
        wr_data = prim_we ? diff.down_left : r_def_data;
    end

    // row carries and the held-back write
    always_comb begin
        n_right     = r_right;
        n_pend_left = r_pend_left;
        n_pend_mid  = r_pend_mid;
        n_def_valid = s1_fire && r_s1_last_col;
        if (s1_fire) begin
            n_right = r_s1_last_col ? '0 : diff.right_share;
            if (r_s1_last_col) begin
                n_pend_left = '0;
                n_pend_mid  = '0;
            end else begin
                n_pend_left = diff.down_mid;
                n_pend_mid  = diff.down_right;
            end
        end
    end

    // forwarding for the waiting pixel: a write to its column after the ram read was issued
    always_comb begin
        n_fwd_valid = r_fwd_valid;
        n_fwd_data  = r_fwd_data;
        if (accept) begin
            n_fwd_valid = wr_en && (wr_addr == col_now);
            n_fwd_data  = wr_data;
        end else if (r_s1_valid && !s1_fire && wr_en && wr_addr == r_s1_col) begin
            n_fwd_valid = 1'b1;
            n_fwd_data  = wr_data;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (i_result_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_right     <= '0;
            r_pend_left <= '0;
            r_pend_mid  <= '0;
            r_def_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_THRESHOLD:    r_threshold <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1_valid  <= n_s1_valid;
            r_fwd_valid <= n_fwd_valid;
            r_right     <= n_right;
            r_pend_left <= n_pend_left;
            r_pend_mid  <= n_pend_mid;
            r_def_valid <= n_def_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fwd_data <= n_fwd_data;
        if (accept) begin
            r_s1_pix      <= i_pixel_in;
            r_s1_col      <= col_now;
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
            r_s1_row0     <= (r_row == '0);
        end
        if (s1_fire) begin
            r_def_addr  <= r_s1_col;
            r_def_data  <= diff.down_mid;
            r_pixel_out <= diff.white ? PIX_WHITE : PIX_BLACK;
            r_eor       <= r_s1_last_col;
            r_eof       <= r_s1_last_col && r_s1_last_row;
        end
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= line_mem[col_now];
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

// ===== hdl/efd_diffuse.sv =====
// per-pixel arithmetic: corrected value, black/white decision and the four error shares
// depends on efd_pkg
module efd_diffuse (
    input  logic [efd_pkg::PIX_W-1:0] i_pixel,
    input  efd_pkg::t_err             i_incoming,
    input  efd_pkg::t_err             i_right,
    input  efd_pkg::t_err             i_pend_left,
    input  efd_pkg::t_err             i_pend_mid,
    input  logic                      i_first_col,
    input  logic [efd_pkg::THR_W-1:0] i_threshold,
    output efd_pkg::t_diffuse         o_diffuse
);
    import efd_pkg::*;

    logic signed [12:0] sum;
    t_err               corr;
    logic               white;
    logic signed [11:0] err;
    logic signed [14:0] err_x;
    logic signed [14:0] prod7;
    logic signed [14:0] prod5;
    logic signed [14:0] prod3;
    t_err               share5;

    always_comb begin
        sum   = $signed({5'b0, i_pixel}) + ext13(i_incoming) + ext13(i_right);
        corr  = sat11(sum);
        white = (corr >= $signed({3'b0, i_threshold}));
        err   = $signed({corr[ERR_W-1], corr}) - (white ? 12'sd255 : 12'sd0);
        err_x = $signed({{3{err[11]}}, err});
        prod7 = err_x * 15'sd7;
        prod5 = err_x * 15'sd5;
        prod3 = err_x * 15'sd3;
        share5 = div16(prod5);

        o_diffuse.white       = white;
        o_diffuse.right_share = div16(prod7);
        o_diffuse.down_left   = sat11(ext13(i_pend_left) + ext13(div16(prod3)));
        // first column starts a fresh partial sum below
        o_diffuse.down_mid    = i_first_col ? share5 : sat11(ext13(i_pend_mid) + ext13(share5));
        o_diffuse.down_right  = div16(err_x);
    end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for error_diffusion_dither: floyd-steinberg dither of grey pixel rows
// depends on efd_pkg and the error_diffusion_dither rtl; holds its own prediction of the dither
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import efd_pkg::*;

    localparam int LINE_MAX     = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 8;

    // one dithered pixel as it leaves the block
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } t_dither_result;

    // dut-facing signals; every one the bench drives is known from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    t_cfg_index            cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    logic [PIX_W-1:0]      pixel_in    = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  end_of_row;
    logic                  end_of_frame;

    // traffic shaping, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // long receiver hold-off: the test bumps the request, the receiver counts it down
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int error_count = 0;

    // predicted dither state and register copy
    logic [WIDTH_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
    logic [THR_W-1:0]    cfg_thr    = THRESHOLD_RESET;
    t_err                line_err [LINE_MAX];
    t_err                carry_right   = '0;
    t_err                acc_down_left = '0;
    t_err                acc_down      = '0;
    int unsigned         col_pos       = 0;
    logic [HEIGHT_W-1:0] row_pos       = '0;

    t_dither_result expected_pixels [$];

    error_diffusion_dither uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_pixel_valid  (pixel_valid),
        .o_pixel_ready  (pixel_ready),
        .i_pixel_in     (pixel_in),
        .o_result_valid (result_valid),
        .i_result_ready (result_ready),
        .o_pixel_out    (pixel_out),
        .o_end_of_row   (end_of_row),
        .o_end_of_frame (end_of_frame)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // clamp a corrected value or an error sum to the signed 11-bit range
    function automatic int clamp_err(input int v);
        if (v > 1023) begin
            return 1023;
        end
        if (v < -1024) begin
            return -1024;
        end
        return v;
    endfunction

    // advance the predicted dither by one accepted pixel and queue its output
    function automatic void predict_dither(input logic [PIX_W-1:0] pix);
        int             w;
        int             h;
        int             col;
        int             incoming;
        int             corr;
        int             outv;
        int             err;
        logic           last_col;
        logic           last_row;
        t_dither_result res;
        // out-of-range sizes are clamped, counters left over from a larger size end early
        w = int'(cfg_width);
        if (w < 1) begin
            w = 1;
        end
        if (w > LINE_MAX) begin
            w = LINE_MAX;
        end
        h = int'(cfg_height);
        if (h < 1) begin
            h = 1;
        end
        col = int'(col_pos);
        if (col >= w) begin
            col = w - 1;
        end
        last_col = (col == w - 1);
        last_row = (int'(row_pos) >= h - 1);

        // row 0 of a frame takes nothing from above
        incoming = (row_pos == 0) ? 0 : int'(line_err[col]);
        if (col == 0) begin
            carry_right = '0;
        end
        corr = clamp_err(int'(pix) + incoming + int'(carry_right));
        outv = (corr >= int'(cfg_thr)) ? 255 : 0;
        err  = corr - outv;

        // 7/16 right, 3/16 down-left, 5/16 down, 1/16 down-right, all truncated toward zero
        carry_right = last_col ? t_err'(0) : t_err'((err * 7) / 16);
        if (col == 0) begin
            acc_down = t_err'((err * 5) / 16);
        end else begin
            line_err[col-1] = t_err'(clamp_err(int'(acc_down_left) + (err * 3) / 16));
            acc_down        = t_err'(clamp_err(int'(acc_down) + (err * 5) / 16));
        end
        if (last_col) begin
            line_err[col] = acc_down;
            acc_down_left = '0;
            acc_down      = '0;
            col_pos       = 0;
            row_pos       = last_row ? '0 : row_pos + 1'b1;
        end else begin
            acc_down_left = acc_down;
            acc_down      = t_err'(err / 16);
            col_pos       = col + 1;
        end

        res.pixel     = outv[PIX_W-1:0];
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        expected_pixels.push_back(res);
    endfunction

    // offer one pixel, with random idle cycles ahead of it, and wait for the transaction
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_in    <= pix;
        do begin
            @(posedge clk);
        end while (!pixel_ready);
        predict_dither(pix);
    endtask

    // stop offering, let every expected pixel come out, then let the line store write-back settle
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // write all three registers back to back; only called while the block is idle
    task automatic program_regs(input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        cfg_width  = w[WIDTH_W-1:0];
        cfg_height = h[HEIGHT_W-1:0];
        cfg_thr    = thr[THR_W-1:0];
    endtask

    // random grey level: extremes, values around the threshold, or anything
    function automatic logic [PIX_W-1:0] random_pixel();
        int v;
        case ($urandom_range(9))
            0: begin
                v = 0;
            end
            1: begin
                v = 255;
            end
            2, 3: begin
                v = int'(cfg_thr) + int'($urandom_range(6)) - 3;
            end
            default: begin
                v = int'($urandom_range(255));
            end
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v[PIX_W-1:0];
    endfunction

    // small frame with both grey extremes, mid-grey and the values either side of the threshold
    task automatic test_basic_frame();
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
        program_regs(16'd4, 16'd3, 16'd128);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd1);
        send_pixel(8'd254);
        send_pixel(8'd64);
        send_pixel(8'd192);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
    endtask

    // threshold at both ends of its range
    task automatic test_threshold_extremes();
        wait_drained();
        program_regs(16'd3, 16'd2, 16'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd0);
        send_pixel(8'd1);
        wait_drained();
        program_regs(16'd3, 16'd2, 16'd255);
        send_pixel(8'd254);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd254);
        send_pixel(8'd254);
        send_pixel(8'd127);
    endtask

    // zero width and height count as one: every pixel ends its row and its frame
    task automatic test_size_clamps();
        wait_drained();
        program_regs(16'd0, 16'd0, 16'd100);
        send_pixel(8'd99);
        send_pixel(8'd100);
        send_pixel(8'd255);
        wait_drained();
        program_regs(16'd1, 16'd1, 16'd128);
        send_pixel(8'd128);
        send_pixel(8'd127);
    endtask

    // wide row read back by a second row, then an oversized width cut short by a small one
    task automatic test_wide_rows();
        wait_drained();
        program_regs(16'd96, 16'd2, 16'd128);
        repeat (2 * 96) send_pixel(random_pixel());
        wait_drained();
        // oversized width: no row end within the first 40 pixels
        program_regs(16'd2047, 16'd1, 16'd77);
        repeat (40) send_pixel(random_pixel());
        wait_drained();
        // column 40 is past the last column now, so the next pixel ends row and frame
        program_regs(16'd40, 16'd1, 16'd77);
        send_pixel(random_pixel());
    endtask

    // size registers changed part way through a frame: the counters run on and end early
    task automatic test_midframe_change();
        wait_drained();
        program_regs(16'd5, 16'd65535, 16'd128);
        // two whole rows and three pixels into the third
        repeat (13) send_pixel(random_pixel());
        wait_drained();
        // column 3 is now past the last column and row 2 past the last row
        program_regs(16'd2, 16'd1, 16'd128);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        send_pixel(random_pixel());
    endtask

    // whole frames of random size and content under one traffic pattern
    task automatic run_random_phase(input int unsigned idle_pct,
                                    input int unsigned hold_pct,
                                    input int          target);
        int          sent;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned thr_raw;
        int          w_eff;
        int          h_eff;
        int          frames;
        sent = 0;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        while (sent < target) begin
            wait_drained();
            case ($urandom_range(19))
                0: begin
                    w_raw = 0;
                end
                1, 2, 3: begin
                    w_raw = $urandom_range(13, 40);
                end
                default: begin
                    w_raw = $urandom_range(1, 12);
                end
            endcase
            h_raw = $urandom_range(1, 3);
            case ($urandom_range(9))
                0: begin
                    thr_raw = 0;
                end
                1: begin
                    thr_raw = 255;
                end
                default: begin
                    thr_raw = $urandom_range(255);
                end
            endcase
            program_regs(w_raw[15:0], h_raw[15:0], thr_raw[15:0]);
            w_eff  = (w_raw == 0) ? 1 : int'(w_raw);
            h_eff  = int'(h_raw);
            frames = $urandom_range(1, 2);
            // one or two frames back to back under one setting
            repeat (frames * w_eff * h_eff) send_pixel(random_pixel());
            sent += frames * w_eff * h_eff;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 60);
        run_random_phase(55, 0, 60);
        run_random_phase(0, 55, 60);
        run_random_phase(25, 25, 60);
    endtask

    // receiver holds off for a long stretch while pixels keep coming, so the input stalls
    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
        program_regs(16'd8, 16'd4, 16'd128);
        hold_req++;
        repeat (32) send_pixel(random_pixel());
    endtask

    // receiver side: random stalls, plus the long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    = hold_left - 1;
            result_ready <= 1'b0;
        end else begin
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare every output transaction with the oldest predicted pixel
    always @(posedge clk) begin : check_results
        t_dither_result want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_out %0d end_of_row %0b end_of_frame %0b",
                       pixel_out, end_of_row, end_of_frame);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (pixel_out !== want.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
                    error_count++;
                end
                if (end_of_row !== want.row_end) begin
                    $error("end_of_row: expected %0b, got %0b", want.row_end, end_of_row);
                    error_count++;
                end
                if (end_of_frame !== want.frame_end) begin
                    $error("end_of_frame: expected %0b, got %0b", want.frame_end, end_of_frame);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frame();
        test_threshold_extremes();
        test_size_clamps();
        test_midframe_change();
        test_wide_rows();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
